// ----- rtl/hkth_pkg.sv -----
// Shared constants, types and helper functions for the two-level histogram selector.
package hkth_pkg;

    localparam int VALUE_BITS  = 18;
    localparam int BUCKET_BITS = 10;
    localparam int COUNT_BITS  = 19;

    localparam int SHIFT_BITS    = (BUCKET_BITS < VALUE_BITS) ? BUCKET_BITS : VALUE_BITS;
    localparam int BKT_RAW_BITS  = VALUE_BITS - SHIFT_BITS;
    localparam int BKT_IDX_BITS  = (BKT_RAW_BITS > 0) ? BKT_RAW_BITS : 1;
    localparam int NUM_BUCKETS   = 1 << BKT_RAW_BITS;

    localparam int OPCODE_W = 2;
    localparam int VALUE_W  = 18;
    localparam int RANK_W   = 19;
    localparam int STATUS_W = 2;
    localparam int TOTAL_W  = 19;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    typedef enum logic [OPCODE_W-1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_SELECT = 2'd2,
        OP_NONE   = 2'd3
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_BAD_RANK = 2'd1,
        ST_ABSENT   = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_UPDATE,
        S_BSCAN,
        S_FSCAN,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic                  we;
        logic [VALUE_BITS-1:0] waddr;
        logic [COUNT_BITS-1:0] wdata;
        logic [VALUE_BITS-1:0] raddr;
    } fine_port_t;

    typedef struct packed {
        logic                    we;
        logic [BKT_IDX_BITS-1:0] waddr;
        logic [COUNT_BITS-1:0]   wdata;
        logic [BKT_IDX_BITS-1:0] raddr;
    } bkt_port_t;

    function automatic logic [BKT_IDX_BITS-1:0] bucket_of(input logic [VALUE_BITS-1:0] v);
        return BKT_IDX_BITS'(v >> SHIFT_BITS);
    endfunction

    function automatic logic [VALUE_BITS-1:0] bucket_base(input logic [BKT_IDX_BITS-1:0] b);
        return VALUE_BITS'(VALUE_BITS'(b) << SHIFT_BITS);
    endfunction

endpackage

// ----- rtl/hkth_ram.sv -----
// Generic simple dual-port synchronous RAM with registered read.
module hkth_ram #(
    parameter int ADDR_BITS = 8,
    parameter int DATA_BITS = 19
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [DATA_BITS-1:0] wdata,
    input  logic [ADDR_BITS-1:0] raddr,
    output logic [DATA_BITS-1:0] rdata
);

    logic [DATA_BITS-1:0] mem [2**ADDR_BITS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/hkth_ctrl.sv -----
// Sequencer for clearing, count updates, the two-level rank walk and the output register.
module hkth_ctrl (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [hkth_pkg::OPCODE_W-1:0]         opcode,
    input  logic [hkth_pkg::VALUE_W-1:0]          value,
    input  logic [hkth_pkg::RANK_W-1:0]           rank,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [hkth_pkg::VALUE_W-1:0]          selected_value,
    output logic [hkth_pkg::STATUS_W-1:0]         status,
    output logic [hkth_pkg::TOTAL_W-1:0]          total_count,
    output hkth_pkg::fine_port_t                  fine_port,
    input  logic [hkth_pkg::COUNT_BITS-1:0]       fine_rdata,
    output hkth_pkg::bkt_port_t                   bkt_port,
    input  logic [hkth_pkg::COUNT_BITS-1:0]       bkt_rdata
);

    hkth_pkg::state_t                        state_reg, state_next;
    logic [hkth_pkg::VALUE_BITS-1:0]         clr_reg, clr_next;
    logic [hkth_pkg::COUNT_BITS-1:0]         total_reg, total_next;
    logic                                    out_valid_reg, out_valid_next;

    hkth_pkg::opcode_t                       op_reg, op_next;
    logic [hkth_pkg::VALUE_BITS-1:0]         val_reg, val_next;
    logic [hkth_pkg::BKT_IDX_BITS-1:0]       bkt_reg, bkt_next;
    logic [hkth_pkg::COUNT_BITS-1:0]         left_reg, left_next;
    hkth_pkg::status_t                       status_reg, status_next;
    logic [hkth_pkg::VALUE_BITS-1:0]         sel_reg, sel_next;
    logic [hkth_pkg::VALUE_W-1:0]            out_sel_reg, out_sel_next;
    hkth_pkg::status_t                       out_status_reg, out_status_next;
    logic [hkth_pkg::TOTAL_W-1:0]            out_total_reg, out_total_next;

    logic                                    out_free;
    logic                                    last_bkt;
    logic                                    last_fine;
    hkth_pkg::opcode_t                       in_op;
    logic [hkth_pkg::VALUE_BITS-1:0]         in_val;

    assign in_stall       = (state_reg != hkth_pkg::S_IDLE);
    assign out_valid      = out_valid_reg;
    assign selected_value = out_sel_reg;
    assign status         = out_status_reg;
    assign total_count    = out_total_reg;

    assign out_free  = !out_valid_reg || !out_stall;
    assign last_bkt  = (32'(bkt_reg) == hkth_pkg::NUM_BUCKETS - 1);
    assign last_fine = &val_reg[hkth_pkg::SHIFT_BITS-1:0];
    assign in_op     = hkth_pkg::opcode_t'(opcode);
    assign in_val    = hkth_pkg::VALUE_BITS'(value);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hkth_pkg::S_CLEAR;
            clr_reg       <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        val_reg        <= val_next;
        bkt_reg        <= bkt_next;
        left_reg       <= left_next;
        status_reg     <= status_next;
        sel_reg        <= sel_next;
        out_sel_reg    <= out_sel_next;
        out_status_reg <= out_status_next;
        out_total_reg  <= out_total_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        total_next      = total_reg;
        out_valid_next  = out_valid_reg && out_stall;
        op_next         = op_reg;
        val_next        = val_reg;
        bkt_next        = bkt_reg;
        left_next       = left_reg;
        status_next     = status_reg;
        sel_next        = sel_reg;
        out_sel_next    = out_sel_reg;
        out_status_next = out_status_reg;
        out_total_next  = out_total_reg;

        fine_port.we    = 1'b0;
        fine_port.waddr = val_reg;
        fine_port.wdata = '0;
        fine_port.raddr = val_reg;
        bkt_port.we     = 1'b0;
        bkt_port.waddr  = hkth_pkg::bucket_of(val_reg);
        bkt_port.wdata  = '0;
        bkt_port.raddr  = bkt_reg;

        unique case (state_reg)
            hkth_pkg::S_CLEAR:
            begin
                fine_port.we    = 1'b1;
                fine_port.waddr = clr_reg;
                bkt_port.we     = 1'b1;
                bkt_port.waddr  = hkth_pkg::BKT_IDX_BITS'(clr_reg);
                clr_next        = clr_reg + 1'b1;
                if (&clr_reg)
                begin
                    state_next = hkth_pkg::S_IDLE;
                end
            end
            hkth_pkg::S_IDLE:
            begin
                fine_port.raddr = in_val;
                bkt_port.raddr  = (in_op == hkth_pkg::OP_SELECT) ? '0
                                                                 : hkth_pkg::bucket_of(in_val);
                if (in_valid)
                begin
                    op_next     = in_op;
                    val_next    = in_val;
                    bkt_next    = '0;
                    status_next = hkth_pkg::ST_OK;
                    sel_next    = '0;
                    case (in_op)
                        hkth_pkg::OP_INSERT:
                        begin
                            if (total_reg == hkth_pkg::COUNT_MAX)
                            begin
                                status_next = hkth_pkg::ST_FULL;
                                state_next  = hkth_pkg::S_FINISH;
                            end
                            else
                            begin
                                state_next = hkth_pkg::S_UPDATE;
                            end
                        end
                        hkth_pkg::OP_DELETE:
                        begin
                            state_next = hkth_pkg::S_UPDATE;
                        end
                        hkth_pkg::OP_SELECT:
                        begin
                            if (rank == '0 || 32'(rank) > 32'(total_reg))
                            begin
                                status_next = hkth_pkg::ST_BAD_RANK;
                                state_next  = hkth_pkg::S_FINISH;
                            end
                            else
                            begin
                                left_next  = hkth_pkg::COUNT_BITS'(rank - 1'b1);
                                state_next = hkth_pkg::S_BSCAN;
                            end
                        end
                        default:
                        begin
                            state_next = hkth_pkg::S_FINISH;
                        end
                    endcase
                end
            end
            hkth_pkg::S_UPDATE:
            begin
                state_next = hkth_pkg::S_FINISH;
                if (op_reg == hkth_pkg::OP_INSERT)
                begin
                    fine_port.we    = 1'b1;
                    fine_port.wdata = fine_rdata + 1'b1;
                    bkt_port.we     = 1'b1;
                    bkt_port.wdata  = bkt_rdata + 1'b1;
                    total_next      = total_reg + 1'b1;
                end
                else if (fine_rdata == '0)
                begin
                    status_next = hkth_pkg::ST_ABSENT;
                end
                else
                begin
                    fine_port.we    = 1'b1;
                    fine_port.wdata = fine_rdata - 1'b1;
                    bkt_port.we     = 1'b1;
                    bkt_port.wdata  = bkt_rdata - 1'b1;
                    total_next      = total_reg - 1'b1;
                end
            end
            hkth_pkg::S_BSCAN:
            begin
                fine_port.raddr = hkth_pkg::bucket_base(bkt_reg);
                bkt_port.raddr  = bkt_reg + 1'b1;
                if (last_bkt || bkt_rdata > left_reg)
                begin
                    val_next   = hkth_pkg::bucket_base(bkt_reg);
                    state_next = hkth_pkg::S_FSCAN;
                end
                else
                begin
                    left_next = left_reg - bkt_rdata;
                    bkt_next  = bkt_reg + 1'b1;
                end
            end
            hkth_pkg::S_FSCAN:
            begin
                fine_port.raddr = val_reg + 1'b1;
                if (last_fine || fine_rdata > left_reg)
                begin
                    sel_next   = val_reg;
                    state_next = hkth_pkg::S_FINISH;
                end
                else
                begin
                    left_next = left_reg - fine_rdata;
                    val_next  = val_reg + 1'b1;
                end
            end
            hkth_pkg::S_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_sel_next    = hkth_pkg::VALUE_W'(sel_reg);
                    out_status_next = status_reg;
                    out_total_next  = hkth_pkg::TOTAL_W'(total_reg);
                    state_next      = hkth_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = hkth_pkg::S_IDLE;
            end
        endcase
    end

    a_both_stores_written: assert property (@(posedge clk) disable iff (!rst_n)
        fine_port.we == bkt_port.we)
        else $error("Value and bucket count writes are not paired.");

    a_insert_raises_total: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == hkth_pkg::S_UPDATE && op_reg == hkth_pkg::OP_INSERT)
        |=> total_reg == $past(total_reg) + 1'b1)
        else $error("An insert did not raise the stored total.");

    a_rank_never_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == hkth_pkg::S_BSCAN || state_reg == hkth_pkg::S_FSCAN)
        |=> left_reg <= $past(left_reg))
        else $error("Remaining rank grew during the walk.");

    a_finish_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == hkth_pkg::S_FINISH && out_free)
        |=> out_valid_reg && state_reg == hkth_pkg::S_IDLE)
        else $error("A finished transaction was not presented.");

endmodule

// ----- rtl/two_level_histogram_kth_select.sv -----
// Top level of the two-level counting histogram with k-th smallest selection.
//
// Input channel: in_valid/in_stall with opcode, value and rank. Opcode 0 inserts
// value, 1 deletes it and 2 returns the rank-th smallest stored value.
// Output channel: out_valid/out_stall with selected_value, status and total_count,
// exactly one result transaction for each input transaction, in order.
// One transaction is worked on at a time. An insert or a delete passes through
// the update state and then the finish state, which loads the result register.
// An insert at full count, a select with a bad rank or the unused opcode goes
// straight to the finish state. A select walks the bucket counts in order (1 to
// 256 reads) and then the value counts inside the chosen bucket (1 to 1024
// reads) before the finish state; each count memory has a single read port.
// The next transaction can be accepted at the clock edge after the one that
// loads the result register. After reset both count memories are swept to zero,
// one entry per cycle, and in_stall stays high during that pass.
// The result sits in an output register; a new transaction is accepted while it
// waits. If out_stall holds the register full when the next result is ready,
// the block holds that result and keeps in_stall high until the register frees.
module two_level_histogram_kth_select (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [hkth_pkg::OPCODE_W-1:0]    opcode,
    input  logic [hkth_pkg::VALUE_W-1:0]     value,
    input  logic [hkth_pkg::RANK_W-1:0]      rank,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [hkth_pkg::VALUE_W-1:0]     selected_value,
    output logic [hkth_pkg::STATUS_W-1:0]    status,
    output logic [hkth_pkg::TOTAL_W-1:0]     total_count
);

    hkth_pkg::fine_port_t              fine_port;
    hkth_pkg::bkt_port_t               bkt_port;
    logic [hkth_pkg::COUNT_BITS-1:0]   fine_rdata;
    logic [hkth_pkg::COUNT_BITS-1:0]   bkt_rdata;

    hkth_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .opcode         (opcode),
        .value          (value),
        .rank           (rank),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .selected_value (selected_value),
        .status         (status),
        .total_count    (total_count),
        .fine_port      (fine_port),
        .fine_rdata     (fine_rdata),
        .bkt_port       (bkt_port),
        .bkt_rdata      (bkt_rdata)
    );

    hkth_ram #(
        .ADDR_BITS (hkth_pkg::VALUE_BITS),
        .DATA_BITS (hkth_pkg::COUNT_BITS)
    ) u_fine_ram (
        .clk   (clk),
        .we    (fine_port.we),
        .waddr (fine_port.waddr),
        .wdata (fine_port.wdata),
        .raddr (fine_port.raddr),
        .rdata (fine_rdata)
    );

    hkth_ram #(
        .ADDR_BITS (hkth_pkg::BKT_IDX_BITS),
        .DATA_BITS (hkth_pkg::COUNT_BITS)
    ) u_bkt_ram (
        .clk   (clk),
        .we    (bkt_port.we),
        .waddr (bkt_port.waddr),
        .wdata (bkt_port.wdata),
        .raddr (bkt_port.raddr),
        .rdata (bkt_rdata)
    );

endmodule

// ----- tb/histogram_checker.sv -----
// Checker that predicts every result of the histogram selector and compares it.
module histogram_checker
    import hkth_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_stall,
    input  logic [OPCODE_W-1:0] opcode,
    input  logic [VALUE_W-1:0]  value,
    input  logic [RANK_W-1:0]   rank,
    input  logic                out_valid,
    input  logic                out_stall,
    input  logic [VALUE_W-1:0]  selected_value,
    input  logic [STATUS_W-1:0] status,
    input  logic [TOTAL_W-1:0]  total_count,
    output int                  errors,
    output int                  pending,
    output int                  checked
);

    localparam int VALUE_SPAN  = 1 << VALUE_BITS;
    localparam int BUCKET_SPAN = 1 << SHIFT_BITS;

    typedef struct packed {
        logic [VALUE_W-1:0] sel;
        status_t            st;
        logic [TOTAL_W-1:0] total;
    } answer_t;

    logic [COUNT_BITS-1:0] value_tally [VALUE_SPAN];
    logic [COUNT_BITS-1:0] bucket_tally [NUM_BUCKETS];
    logic [COUNT_BITS-1:0] held_total;
    answer_t               answer_q [$];
    int                    fail_count;
    int                    result_count;

    function automatic answer_t apply_histogram_op(input opcode_t op,
                                                   input logic [VALUE_BITS-1:0] v,
                                                   input logic [RANK_W-1:0] k);
        answer_t     a;
        int unsigned bkt;
        int unsigned left;
        int unsigned pos;
        int unsigned last;
        a.sel = '0;
        a.st  = ST_OK;
        bkt   = (int'(v) >> SHIFT_BITS) & (NUM_BUCKETS - 1);
        case (op)
            OP_INSERT:
            begin
                if (held_total == COUNT_MAX)
                begin
                    a.st = ST_FULL;
                end
                else
                begin
                    value_tally[v]    = value_tally[v] + 1'b1;
                    bucket_tally[bkt] = bucket_tally[bkt] + 1'b1;
                    held_total        = held_total + 1'b1;
                end
            end
            OP_DELETE:
            begin
                if (value_tally[v] == '0)
                begin
                    a.st = ST_ABSENT;
                end
                else
                begin
                    value_tally[v]    = value_tally[v] - 1'b1;
                    bucket_tally[bkt] = bucket_tally[bkt] - 1'b1;
                    held_total        = held_total - 1'b1;
                end
            end
            OP_SELECT:
            begin
                if (k == '0 || 32'(k) > 32'(held_total))
                begin
                    a.st = ST_BAD_RANK;
                end
                else
                begin
                    left = k - 1;
                    bkt  = 0;
                    while (bkt < NUM_BUCKETS - 1 && bucket_tally[bkt] <= left)
                    begin
                        left = left - bucket_tally[bkt];
                        bkt  = bkt + 1;
                    end
                    pos  = bkt << SHIFT_BITS;
                    last = pos + BUCKET_SPAN - 1;
                    while (pos < last && value_tally[pos] <= left)
                    begin
                        left = left - value_tally[pos];
                        pos  = pos + 1;
                    end
                    a.sel = VALUE_W'(pos);
                end
            end
            default:
            begin
            end
        endcase
        a.total = TOTAL_W'(held_total);
        return a;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        answer_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < VALUE_SPAN; i++)
            begin
                value_tally[i] = '0;
            end
            for (int i = 0; i < NUM_BUCKETS; i++)
            begin
                bucket_tally[i] = '0;
            end
            held_total = '0;
            answer_q.delete();
            fail_count   = 0;
            result_count = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                answer_q = {answer_q, apply_histogram_op(opcode_t'(opcode), value, rank)};
            end
            if (out_valid && !out_stall)
            begin
                result_count++;
                if (answer_q.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, got %0d %0d %0d",
                             $time, selected_value, status, total_count);
                    fail_count++;
                end
                else
                begin
                    want = answer_q.pop_front();
                    if (selected_value !== want.sel)
                    begin
                        $display("%0t: selected_value mismatch, expected %0d, got %0d",
                                 $time, want.sel, selected_value);
                        fail_count++;
                    end
                    if (status !== want.st)
                    begin
                        $display("%0t: status field mismatch, expected %0d, got %0d",
                                 $time, want.st, status);
                        fail_count++;
                    end
                    if (total_count !== want.total)
                    begin
                        $display("%0t: total_count mismatch, expected %0d, got %0d",
                                 $time, want.total, total_count);
                        fail_count++;
                    end
                end
            end
        end
        errors  <= fail_count;
        pending <= answer_q.size();
        checked <= result_count;
    end

endmodule

// ----- tb/testbench.sv -----
// Top of the testbench: clock, reset, stimulus, output stalls, watchdog and verdict.
module testbench;
    import hkth_pkg::*;

    localparam int WATCHDOG_LIMIT = 800000;
    localparam int DRAIN_CYCLES   = 1400;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [OPCODE_W-1:0] opcode = '0;
    logic [VALUE_W-1:0]  value = '0;
    logic [RANK_W-1:0]   rank = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [VALUE_W-1:0]  selected_value;
    logic [STATUS_W-1:0] status;
    logic [TOTAL_W-1:0]  total_count;

    int errors;
    int pending;
    int checked;
    int quiet_cycles = 0;
    bit noisy = 1'b0;
    int n_insert = 0;
    int n_delete = 0;
    int n_select = 0;
    int n_unused = 0;

    logic [VALUE_W-1:0] live_values [$];

    always #10 clk = ~clk;

    two_level_histogram_kth_select dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .opcode         (opcode),
        .value          (value),
        .rank           (rank),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .selected_value (selected_value),
        .status         (status),
        .total_count    (total_count)
    );

    histogram_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .opcode         (opcode),
        .value          (value),
        .rank           (rank),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .selected_value (selected_value),
        .status         (status),
        .total_count    (total_count),
        .errors         (errors),
        .pending        (pending),
        .checked        (checked)
    );

    always @(posedge clk)
    begin
        out_stall <= noisy && ($urandom_range(0, 99) < 32);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("status: fail");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_op(input opcode_t op, input logic [VALUE_W-1:0] v,
                           input logic [RANK_W-1:0] k);
        int idx;
        if (noisy && $urandom_range(0, 99) < 32)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        opcode   <= op;
        value    <= v;
        rank     <= k;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        case (op)
            OP_INSERT:
            begin
                live_values = {live_values, v};
                n_insert++;
            end
            OP_DELETE:
            begin
                idx = -1;
                foreach (live_values[i])
                begin
                    if (idx < 0 && live_values[i] == v)
                    begin
                        idx = i;
                    end
                end
                if (idx >= 0)
                begin
                    live_values.delete(idx);
                end
                n_delete++;
            end
            OP_SELECT: n_select++;
            default: n_unused++;
        endcase
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    function automatic logic [VALUE_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
        begin
            return VALUE_W'($urandom);
        end
        if (r < 35 && live_values.size() > 0)
        begin
            return live_values[$urandom_range(0, live_values.size() - 1)];
        end
        return VALUE_W'(($urandom_range(0, 7) << SHIFT_BITS) | $urandom_range(0, 63));
    endfunction

    task automatic random_op();
        int                 r;
        int                 n;
        logic [VALUE_W-1:0] v;
        logic [RANK_W-1:0]  k;
        r = $urandom_range(0, 99);
        n = live_values.size();
        if (r < 45)
        begin
            send_op(OP_INSERT, pick_value(), RANK_W'($urandom));
        end
        else if (r < 70)
        begin
            if (n > 0 && $urandom_range(0, 9) != 0)
            begin
                v = live_values[$urandom_range(0, n - 1)];
            end
            else
            begin
                v = VALUE_W'($urandom);
            end
            send_op(OP_DELETE, v, RANK_W'($urandom));
        end
        else if (r < 95)
        begin
            if (n > 0 && $urandom_range(0, 9) != 0)
            begin
                k = RANK_W'($urandom_range(1, n));
            end
            else
            begin
                case ($urandom_range(0, 2))
                    0: k = '0;
                    1: k = RANK_W'(n + 1);
                    default: k = RANK_W'($urandom);
                endcase
            end
            send_op(OP_SELECT, VALUE_W'($urandom), k);
        end
        else
        begin
            send_op(OP_NONE, VALUE_W'($urandom), RANK_W'($urandom));
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_op(OP_SELECT, '1, 19'd1);
        send_op(OP_DELETE, '0, '0);
        send_op(OP_INSERT, '0, '1);
        send_op(OP_INSERT, '1, '0);
        send_op(OP_INSERT, '1, '0);
        send_op(OP_INSERT, 18'd1023, '0);
        send_op(OP_INSERT, 18'd1024, '0);
        send_op(OP_SELECT, '0, 19'd1);
        send_op(OP_SELECT, '0, 19'd2);
        send_op(OP_SELECT, '1, 19'd3);
        send_op(OP_SELECT, '0, 19'd5);
        send_op(OP_SELECT, '0, '0);
        send_op(OP_SELECT, '0, 19'd6);
        send_op(OP_SELECT, '0, 19'h40000);
        send_op(OP_NONE, '1, '1);
        send_op(OP_DELETE, '1, '0);
        send_op(OP_DELETE, 18'd5, '0);
        send_op(OP_DELETE, '1, '0);
        send_op(OP_DELETE, '1, '0);
        send_op(OP_SELECT, '0, 19'd3);
        send_op(OP_INSERT, 18'd1023, '0);
        send_op(OP_SELECT, '0, 19'd3);

        wait_drained();
        noisy = 1'b1;
        repeat (200) random_op();
        wait_drained();
        noisy = 1'b0;
        repeat (100) random_op();
        noisy = 1'b1;
        repeat (160) random_op();

        in_valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d inserts, %0d deletes, %0d selects and %0d unused opcodes.",
                 n_insert, n_delete, n_select, n_unused);
        $display("Checked %0d results with random gaps and output stalls on both sides.",
                 checked);
        if (errors == 0 && pending == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/hkth_pkg.sv
rtl/hkth_ram.sv
rtl/hkth_ctrl.sv
rtl/two_level_histogram_kth_select.sv
tb/histogram_checker.sv
tb/testbench.sv
